>>> design/piecewise_linear_interpolator_top_assert.svh
// ----------------------------------------------------------------------------
// Piecewise linear interpolator assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks that an implication holds at every clock edge outside reset.
`define PLI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition in one cycle implies a condition in the next cycle.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLI_ASSERT(label, prop, msg)
`define PLI_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> design/plint_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared widths, the breakpoint word layout, region codes and divider status.
// ----------------------------------------------------------------------------
package plint_pkg;

    // Width of one Q16.16 value.
    localparam int DATA_W = 32;
    // Width of the table index field of a load word.
    localparam int IDX_W = 6;
    // Width of the point count register.
    localparam int CNT_W = 7;

    // One breakpoint as stored in the table memory.
    typedef struct packed {
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] x;
    } point_t;

    // Region codes reported with each result.
    typedef enum logic [1:0] {
        REGION_INTERP  = 2'd0,
        REGION_BELOW   = 2'd1,
        REGION_ABOVE   = 2'd2,
        REGION_NOMATCH = 2'd3
    } region_t;

    // Status of the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> design/piecewise_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table in RAM, sequential segment scan and iterative division.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel. tuser selects the kind: 0 writes
// one breakpoint (x, y) into table entry point_index, 1 queries at x_value.
// A load gives no output word. A query gives one word on the m_axis channel:
// the result in tdata, the region and saturation flag in tuser. The
// breakpoint count is written through cfg_we/cfg_wdata; the user must do so
// only while idle, as the block itself does not enforce it. A query reads
// entry zero and then the last entry in use; a clamped query (below the
// first x, above the last x, or a one-point table) then goes straight to
// the output register. Otherwise the segments are scanned in order, one
// table entry per cycle through the single read port, and the bracketing
// segment goes through the multiplier and the 32-step divider. Queries are
// handled one at a time; s_axis_tready is high only between queries.
// Reset clears the control state and sets point_count to 2; the table holds
// nothing until loaded. When the receiver stalls, a finished result waits in
// the output register; further loads are still taken, and the next query
// finishes and then waits until the output register is free.
// ----------------------------------------------------------------------------
`include "piecewise_linear_interpolator_top_assert.svh"

module piecewise_linear_interpolator_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: point_count.
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0 up: point_index[5:0], x_value[37:6], y_value[69:38],
    // zero padding[71:70].
    input  logic [71:0] s_axis_tdata,
    // Fields from bit 0 up: mode[0].
    input  logic        s_axis_tuser,
    // Output words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0 up: result_value[31:0].
    output logic [31:0] m_axis_tdata,
    // Fields from bit 0 up: region[1:0], saturated[2].
    output logic [2:0]  m_axis_tuser
);

    localparam int W        = plint_pkg::DATA_W;
    localparam int AW       = $clog2(MAX_POINTS);
    localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
    localparam int CW       = (CNT_BITS > plint_pkg::CNT_W) ? CNT_BITS : plint_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_CHK,
        S_SCAN,
        S_MUL,
        S_DIVGO,
        S_DIVWAIT,
        S_OUT
    } state_t;

    // Registers.
    state_t                    state_reg, state_next;
    logic [plint_pkg::CNT_W-1:0] count_reg;
    logic signed [W-1:0]       xq_reg, xq_next;
    logic signed [W-1:0]       prev_x_reg, prev_x_next;
    logic signed [W-1:0]       prev_y_reg, prev_y_next;
    logic signed [W-1:0]       last_y_reg, last_y_next;
    logic [CW-1:0]             scan_idx_reg, scan_idx_next;
    logic [W-1:0]              mag_dx_reg, mag_dx_next;
    logic [W-1:0]              mag_dy_reg, mag_dy_next;
    logic [W-1:0]              mag_dd_reg, mag_dd_next;
    logic                      neg_reg, neg_next;
    logic signed [W-1:0]       base_y_reg, base_y_next;
    logic [2*W-1:0]            prod_reg, prod_next;
    logic [W-1:0]              res_value_reg, res_value_next;
    plint_pkg::region_t        res_region_reg, res_region_next;
    logic                      res_sat_reg, res_sat_next;
    logic                      m_valid_reg, m_valid_next;
    logic [W-1:0]              m_data_reg, m_data_next;
    logic [2:0]                m_user_reg, m_user_next;

    // Unpacked input fields.
    logic [plint_pkg::IDX_W-1:0] in_idx;
    logic signed [W-1:0]         in_x;
    logic signed [W-1:0]         in_y;
    logic                        in_accept;

    // Table memory ports.
    logic                      ram_wr_en;
    logic [AW-1:0]             ram_wr_addr;
    plint_pkg::point_t         ram_wr_data;
    logic                      ram_rd_en;
    logic [AW-1:0]             ram_rd_addr;
    plint_pkg::point_t         ram_rd_data;
    logic signed [W-1:0]       cur_x;
    logic signed [W-1:0]       cur_y;

    // Active point count.
    logic [CW-1:0]             count_ext;
    logic [CW-1:0]             n_w;
    logic [CW-1:0]             last_w;
    logic [CW-1:0]             scan_inc;

    // Segment arithmetic.
    logic [W:0]                dx_w;
    logic [W:0]                dy_w;
    logic [W:0]                dd_w;
    logic [W:0]                dx_abs;
    logic [W:0]                dy_abs;
    logic [W:0]                dd_abs;
    logic                      bracket;

    // Divider.
    logic                      div_start;
    plint_pkg::div_status_t    div_status;
    logic [W-1:0]              div_q;
    logic [W+1:0]              sum_w;
    logic                      sum_ovf;

    assign in_idx    = s_axis_tdata[5:0];
    assign in_x      = s_axis_tdata[37:6];
    assign in_y      = s_axis_tdata[69:38];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Clamp the count register to the range 1 to the table size.
    assign count_ext = CW'(count_reg);
    assign n_w       = (count_ext == '0) ? CW'(1) :
                       ((count_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : count_ext);
    assign last_w    = n_w - CW'(1);
    assign scan_inc  = scan_idx_reg + CW'(1);

    // Breakpoint table.
    plint_ram #(
        .WIDTH ($bits(plint_pkg::point_t)),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cur_x = ram_rd_data.x;
    assign cur_y = ram_rd_data.y;

    // Load words write one entry; indexes past the table are dropped.
    assign ram_wr_en     = in_accept && !s_axis_tuser && (32'(in_idx) < 32'(MAX_POINTS));
    assign ram_wr_addr   = AW'(in_idx);
    assign ram_wr_data.x = in_x;
    assign ram_wr_data.y = in_y;

    // Segment test between the previous entry and the entry just read.
    assign bracket = ((prev_x_reg <= xq_reg) && (cur_x > xq_reg)) ||
                     ((prev_x_reg >= xq_reg) && (cur_x < xq_reg));

    // Differences in one extra bit, and their magnitudes.
    assign dx_w   = {xq_reg[W-1], xq_reg} - {prev_x_reg[W-1], prev_x_reg};
    assign dy_w   = {cur_y[W-1], cur_y} - {prev_y_reg[W-1], prev_y_reg};
    assign dd_w   = {cur_x[W-1], cur_x} - {prev_x_reg[W-1], prev_x_reg};
    assign dx_abs = dx_w[W] ? ((W+1)'(0) - dx_w) : dx_w;
    assign dy_abs = dy_w[W] ? ((W+1)'(0) - dy_w) : dy_w;
    assign dd_abs = dd_w[W] ? ((W+1)'(0) - dd_w) : dd_w;

    // Divider for the scaled offset.
    plint_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (mag_dd_reg),
        .status   (div_status),
        .quotient (div_q)
    );

    assign div_start = (state_reg == S_DIVGO);

    // Final sum with two guard bits for saturation.
    assign sum_w   = neg_reg ?
                     ({{2{base_y_reg[W-1]}}, base_y_reg} - {2'b00, div_q}) :
                     ({{2{base_y_reg[W-1]}}, base_y_reg} + {2'b00, div_q});
    assign sum_ovf = (sum_w[W+1:W-1] != 3'b000) && (sum_w[W+1:W-1] != 3'b111);

    // Next-state logic of the query sequencer and output register.
    always_comb
    begin
        state_next      = state_reg;
        xq_next         = xq_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        last_y_next     = last_y_reg;
        scan_idx_next   = scan_idx_reg;
        mag_dx_next     = mag_dx_reg;
        mag_dy_next     = mag_dy_reg;
        mag_dd_next     = mag_dd_reg;
        neg_next        = neg_reg;
        base_y_next     = base_y_reg;
        prod_next       = prod_reg;
        res_value_next  = res_value_reg;
        res_region_next = res_region_reg;
        res_sat_next    = res_sat_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                // A query reads entry zero first.
                if (in_accept && s_axis_tuser)
                begin
                    xq_next     = in_x;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = '0;
                    state_next  = S_LAST;
                end
            end
            S_LAST:
            begin
                // Keep entry zero and read the last entry in use.
                prev_x_next = cur_x;
                prev_y_next = cur_y;
                ram_rd_en   = 1'b1;
                ram_rd_addr = last_w[AW-1:0];
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                // Clamp below the first x or above the last x, answer a one-point table, or start the scan.
                res_sat_next = 1'b0;
                last_y_next  = cur_y;
                if (xq_reg < prev_x_reg)
                begin
                    res_value_next  = prev_y_reg;
                    res_region_next = plint_pkg::REGION_BELOW;
                    state_next      = S_OUT;
                end
                else if (xq_reg > cur_x)
                begin
                    res_value_next  = cur_y;
                    res_region_next = plint_pkg::REGION_ABOVE;
                    state_next      = S_OUT;
                end
                else if (n_w == CW'(1))
                begin
                    res_value_next  = cur_y;
                    res_region_next = plint_pkg::REGION_NOMATCH;
                    state_next      = S_OUT;
                end
                else
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = AW'(1);
                    scan_idx_next = CW'(1);
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Test one segment per cycle while the next entry is read.
                ram_rd_en   = 1'b1;
                ram_rd_addr = scan_inc[AW-1:0];
                if (bracket)
                begin
                    mag_dx_next = dx_abs[W-1:0];
                    mag_dy_next = dy_abs[W-1:0];
                    mag_dd_next = dd_abs[W-1:0];
                    neg_next    = dx_w[W] ^ dy_w[W] ^ dd_w[W];
                    base_y_next = prev_y_reg;
                    state_next  = S_MUL;
                end
                else if (scan_inc < n_w)
                begin
                    prev_x_next   = cur_x;
                    prev_y_next   = cur_y;
                    scan_idx_next = scan_inc;
                end
                else
                begin
                    res_value_next  = last_y_reg;
                    res_region_next = plint_pkg::REGION_NOMATCH;
                    res_sat_next    = 1'b0;
                    state_next      = S_OUT;
                end
            end
            S_MUL:
            begin
                prod_next  = mag_dx_reg * mag_dy_reg;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                // Add the signed quotient to y0 and saturate.
                if (div_status.done)
                begin
                    res_region_next = plint_pkg::REGION_INTERP;
                    res_sat_next    = sum_ovf;
                    if (sum_ovf)
                    begin
                        res_value_next = sum_w[W+1] ? {1'b1, {(W-1){1'b0}}} :
                                                      {1'b0, {(W-1){1'b1}}};
                    end
                    else
                    begin
                        res_value_next = sum_w[W-1:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Move the result into the output register once it is free.
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_value_reg;
                    m_user_next  = {res_sat_reg, res_region_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state, datapath and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            xq_reg         <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            last_y_reg     <= '0;
            scan_idx_reg   <= '0;
            mag_dx_reg     <= '0;
            mag_dy_reg     <= '0;
            mag_dd_reg     <= '0;
            neg_reg        <= 1'b0;
            base_y_reg     <= '0;
            prod_reg       <= '0;
            res_value_reg  <= '0;
            res_region_reg <= plint_pkg::REGION_INTERP;
            res_sat_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_user_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            xq_reg         <= xq_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            last_y_reg     <= last_y_next;
            scan_idx_reg   <= scan_idx_next;
            mag_dx_reg     <= mag_dx_next;
            mag_dy_reg     <= mag_dy_next;
            mag_dd_reg     <= mag_dd_next;
            neg_reg        <= neg_next;
            base_y_reg     <= base_y_next;
            prod_reg       <= prod_next;
            res_value_reg  <= res_value_next;
            res_region_reg <= res_region_next;
            res_sat_reg    <= res_sat_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
            m_user_reg     <= m_user_next;
        end
    end

    // Point count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= plint_pkg::CNT_W'(2);
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // Assertions.
    `PLI_ASSERT(a_idle_div_quiet, (s_axis_tready |-> !div_status.busy), "divider busy while idle")
    `PLI_ASSERT(a_done_in_wait, (div_status.done |-> (state_reg == S_DIVWAIT)), "stray divider done")
    `PLI_ASSERT_NEXT(a_out_from_seq, (!m_valid_reg && (state_reg != S_OUT)), !m_valid_reg, "output word without a finished query")

endmodule

>>> design/plint_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module plint_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/plint_div.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator divider
// Restoring unsigned divider, one quotient bit per cycle. The dividend's upper
// half must be below the divisor, so the quotient fits in DATA_W bits.
// ----------------------------------------------------------------------------
module plint_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [2*plint_pkg::DATA_W-1:0]  dividend,
    input  logic [plint_pkg::DATA_W-1:0]    divisor,
    output plint_pkg::div_status_t          status,
    output logic [plint_pkg::DATA_W-1:0]    quotient
);

    localparam int W      = plint_pkg::DATA_W;
    localparam int STEP_W = $clog2(W);

    logic [W-1:0]      rem_reg;
    logic [W-1:0]      low_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [W:0]        trial;
    logic              fits;

    // Trial subtraction of the divisor from the shifted remainder.
    assign trial = {rem_reg, low_reg[W-1]};
    assign fits  = trial >= {1'b0, divisor};

    // Iteration control and datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            low_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= dividend[2*W-1:W];
                low_reg  <= dividend[W-1:0];
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
                low_reg  <= {low_reg[W-2:0], fits};
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = low_reg;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Loads breakpoint tables of several shapes and sizes, queries them at exact
// breakpoints, inside segments, just outside the ends and across the full
// range, and compares every output word against a built-in interpolation
// model. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_PTS      = 64;
    localparam int RANDOM_ITEMS = 1350;
    localparam int DRAIN_CYCLES = 120;
    localparam int LIMIT_CYCLES = 1000000;

    // Word kinds carried in tuser.
    localparam bit MODE_LOAD  = 1'b0;
    localparam bit MODE_QUERY = 1'b1;

    // Shapes of the generated breakpoint tables.
    typedef enum int {
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_SCATTER,
        SHAPE_COARSE,
        SHAPE_EXTREME
    } table_shape_t;

    // One input word before packing.
    typedef struct {
        bit               mode;
        bit [5:0]         index;
        bit signed [31:0] x;
        bit signed [31:0] y;
    } pli_word_t;

    // One expected output word.
    typedef struct {
        logic [31:0]        value;
        plint_pkg::region_t region;
        bit                 saturated;
    } interp_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // Fields from bit 0 up: point_index[5:0], x_value[37:6], y_value[69:38],
    // zero padding[71:70].
    logic [71:0] s_axis_tdata = '0;
    // Fields from bit 0 up: mode[0].
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // Fields from bit 0 up: result_value[31:0].
    logic [31:0] m_axis_tdata;
    // Fields from bit 0 up: region[1:0], saturated[2].
    logic [2:0]  m_axis_tuser;

    // Breakpoint table and point count as the block should hold them.
    bit signed [31:0] tbl_x [MAX_PTS];
    bit signed [31:0] tbl_y [MAX_PTS];
    bit [6:0]         tbl_count = 7'd2;

    // The generator's view of the breakpoint x values, used to aim queries.
    bit signed [31:0] planned_x [MAX_PTS];

    pli_word_t      pending_words[$];
    interp_result_t pending_results[$];
    pli_word_t      drive_word;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int items_queued   = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    piecewise_linear_interpolator_top #(
        .MAX_POINTS(MAX_PTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Interpolated or clamped y for a query at xq over the current table.
    function automatic interp_result_t interpolate_at(bit signed [31:0] xq);
        interp_result_t r;
        int n;
        int i;
        bit found;
        bit neg;
        longint xl, x0, x1, y0, y1, dx, dy, dd, sum;
        longint unsigned quot;
        n = tbl_count;
        if (n < 1)
            n = 1;
        if (n > MAX_PTS)
            n = MAX_PTS;
        xl = xq;
        r.saturated = 1'b0;
        found = 1'b0;
        if (xl < longint'(tbl_x[0]))
        begin
            r.value  = tbl_y[0];
            r.region = plint_pkg::REGION_BELOW;
        end
        else if (xl > longint'(tbl_x[n-1]))
        begin
            r.value  = tbl_y[n-1];
            r.region = plint_pkg::REGION_ABOVE;
        end
        else
        begin
            r.value  = tbl_y[n-1];
            r.region = plint_pkg::REGION_NOMATCH;
            for (i = 1; i < n && !found; i++)
            begin
                x0 = tbl_x[i-1];
                x1 = tbl_x[i];
                y0 = tbl_y[i-1];
                y1 = tbl_y[i];
                if ((x0 <= xl && x1 > xl) || (x0 >= xl && x1 < xl))
                begin
                    dx   = xl - x0;
                    dy   = y1 - y0;
                    dd   = x1 - x0;
                    neg  = (dx < 0) != (dy < 0);
                    if (dd < 0)
                        neg = !neg;
                    quot = 0;
                    if (dd != 0)
                        quot = (magnitude(dx) * magnitude(dy)) / magnitude(dd);
                    sum = neg ? y0 - longint'(quot) : y0 + longint'(quot);
                    // Clip the sum to the signed 32-bit range.
                    if (sum > 64'sh7FFF_FFFF)
                    begin
                        sum = 64'sh7FFF_FFFF;
                        r.saturated = 1'b1;
                    end
                    else if (sum < -64'sh8000_0000)
                    begin
                        sum = -64'sh8000_0000;
                        r.saturated = 1'b1;
                    end
                    r.value  = sum[31:0];
                    r.region = plint_pkg::REGION_INTERP;
                    found    = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic bit signed [31:0] pick_extreme();
        case ($urandom_range(4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    task automatic queue_load(bit [5:0] idx, bit signed [31:0] x, bit signed [31:0] y);
        pli_word_t w;
        w.mode  = MODE_LOAD;
        w.index = idx;
        w.x     = x;
        w.y     = y;
        planned_x[idx] = x;
        pending_words.push_back(w);
        items_queued++;
    endtask

    task automatic queue_query(bit signed [31:0] x);
        pli_word_t w;
        w.mode  = MODE_QUERY;
        w.index = 6'($urandom_range(63));
        w.x     = x;
        w.y     = $urandom;
        pending_words.push_back(w);
        items_queued++;
    endtask

    // Wait until every word is taken and every result is back, then let the
    // block settle before anything is reconfigured.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_point_count(bit [6:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tbl_count = v;
        @(negedge clk);
    endtask

    task automatic flag_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // Input driver: takes words from the pending queue and updates the model
    // at the edge where each word is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= MODE_LOAD;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                if (drive_word.mode == MODE_LOAD)
                begin
                    tbl_x[drive_word.index] = drive_word.x;
                    tbl_y[drive_word.index] = drive_word.y;
                end
                else
                    pending_results.push_back(interpolate_at(drive_word.x));
            end
            if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                drive_word = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, drive_word.y, drive_word.x, drive_word.index};
                s_axis_tuser  <= drive_word.mode;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Output monitor: each accepted word is checked against the oldest
    // expected result.
    always @(posedge clk)
    begin : result_check
        interp_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("result word 0x%08h with no query outstanding",
                                        m_axis_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value)
                    flag_mismatch($sformatf("result_value 0x%08h, expected 0x%08h",
                                            m_axis_tdata, want.value));
                if (m_axis_tuser[1:0] !== want.region)
                    flag_mismatch($sformatf("region %0d, expected %0d",
                                            m_axis_tuser[1:0], want.region));
                if (m_axis_tuser[2] !== want.saturated)
                    flag_mismatch($sformatf("saturated %0d, expected %0d",
                                            m_axis_tuser[2], want.saturated));
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int rand_start;
        int progress;
        int n;
        int m;
        int i;
        int j;
        int pick;
        bit [6:0] setting;
        table_shape_t shape;
        longint cur;
        longint step;
        longint lo;
        longint span;
        longint off;
        bit signed [31:0] qx;
        bit signed [31:0] yv;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, at the reset point count of two.
        send_gap_pct   = 7;
        recv_stall_pct = 73;
        // Full-range rising segment.
        queue_load(6'd0, 32'sh8000_0000, 32'sh8000_0000);
        queue_load(6'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        queue_query(32'sh8000_0000);
        queue_query(32'sh0000_0000);
        queue_query(32'sh7FFF_FFFF);
        queue_query(32'sh1234_5678);
        // Falling segment; every query is clamped, as x lies below the first x or above the last x.
        queue_load(6'd0, 32'sh0001_0000, 32'sh7FFF_FFFF);
        queue_load(6'd1, -32'sh0001_0000, 32'sh8000_0000);
        queue_query(32'sh0001_0000);
        queue_query(32'sh0000_0000);
        queue_query(-32'sh0001_0000);
        queue_query(32'sh0002_0000);
        queue_query(-32'sh0002_0000);
        // Negative quotient truncated toward zero.
        queue_load(6'd0, 32'sh0000_0000, 32'sh0000_0000);
        queue_load(6'd1, 32'sh0003_0000, -32'sd5);
        queue_query(32'sh0001_0000);
        queue_query(-32'sd1);
        drain();

        // A count of zero acts as a one-point table.
        set_point_count(7'd0);
        queue_query(32'sh0000_0000);
        queue_query(32'sd5);
        queue_query(-32'sd5);

        // Random part: one table per phase, then queries mixed with stray loads.
        rand_start = items_queued;
        for (i = 0; i < MAX_PTS; i++)
            planned_x[i] = 0;
        for (int phase = 0; items_queued - rand_start < RANDOM_ITEMS; phase++)
        begin
            drain();
            case (phase)
                0: setting = 7'd127;
                1: setting = 7'd1;
                2: setting = 7'd64;
                3: setting = 7'd0;
                4: setting = 7'd3;
                default:
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        setting = 7'($urandom_range(2, 8));
                    else if (pick < 85)
                        setting = 7'($urandom_range(9, 64));
                    else if (pick < 95)
                        setting = 7'($urandom_range(65, 127));
                    else
                        setting = 7'($urandom_range(1));
                end
            endcase
            set_point_count(setting);

            // Idle pattern follows progress through the random part.
            progress = items_queued - rand_start;
            if (progress < RANDOM_ITEMS / 3)
            begin
                send_gap_pct   = 7;
                recv_stall_pct = 73;
            end
            else if (progress < 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct   = 73;
                recv_stall_pct = 7;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end

            n = (setting < 1) ? 1 : ((setting > MAX_PTS) ? MAX_PTS : setting);

            // Fill every entry in use so that no query reads an empty entry.
            shape = table_shape_t'($urandom_range(4));
            cur   = longint'($urandom_range(32'h00FF_FFFF)) - 64'sh0080_0000;
            for (i = 0; i < n; i++)
            begin
                yv = $urandom;
                case (shape)
                    SHAPE_RISING, SHAPE_FALLING:
                    begin
                        step = $urandom_range(1, 32'h0004_0000);
                        cur  = (shape == SHAPE_RISING) ? cur + step : cur - step;
                        qx   = cur[31:0];
                    end
                    SHAPE_SCATTER:
                        qx = $urandom;
                    SHAPE_COARSE:
                        qx = (int'($urandom_range(4)) - 2) * 32'sh0001_0000;
                    default:
                    begin
                        qx = pick_extreme();
                        yv = pick_extreme();
                    end
                endcase
                queue_load(6'(i), qx, yv);
            end

            m = (n > 16) ? $urandom_range(15, 40) : $urandom_range(20, 50);
            for (j = 0; j < m; j++)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    queue_load(6'($urandom_range(63)), $urandom, $urandom);
                else if (pick < 38)
                    queue_query(planned_x[$urandom_range(n - 1)]);
                else if (pick < 66)
                begin
                    // Somewhere inside one segment, its first x included and its last x excluded.
                    i    = (n > 1) ? $urandom_range(n - 2) : 0;
                    lo   = planned_x[i];
                    span = longint'(planned_x[(n > 1) ? i + 1 : 0]) - lo;
                    off  = (span == 0) ? 0 : longint'($urandom) % magnitude(span);
                    cur  = (span > 0) ? lo + off : lo - off;
                    queue_query(cur[31:0]);
                end
                else if (pick < 76)
                    queue_query($urandom_range(1) ? planned_x[0] - 32'sd1
                                                  : planned_x[n - 1] + 32'sd1);
                else if (pick < 92)
                    queue_query($urandom);
                else
                    queue_query($urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
            end
        end

        drain();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
